### hw/rtl/b64e_pkg.sv
`default_nettype none
package b64e_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SEXTET_W = 6;
  localparam int unsigned GROUP_W  = 3 * BYTE_W;

  localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;   // '='
  localparam logic [BYTE_W-1:0] PLUS_CHAR = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] SLASH_CHAR = 8'h2F; // '/'

  // symbol position within a group of four
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] symbol;
    logic              last_symbol;
  } out_item_t;

  // closed group handed from front to back
  typedef struct packed {
    logic [GROUP_W-1:0] bits;
    logic [1:0]         nbytes;  // 1..3 real bytes
    logic               eom;
  } group_t;

  function automatic logic [BYTE_W-1:0] b64_char(input logic [SEXTET_W-1:0] s);
    logic [BYTE_W-1:0] s8;
    logic [BYTE_W-1:0] c;
    s8 = {2'b00, s};
    if (s8 < 8'd26) begin
      c = s8 + 8'd65;
    end else if (s8 < 8'd52) begin
      c = s8 + 8'd71;             // 'a' - 26
    end else if (s8 < 8'd62) begin
      c = s8 - 8'd4;              // '0' - 52
    end else if (s8 == 8'd62) begin
      c = PLUS_CHAR;
    end else begin
      c = SLASH_CHAR;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/b64e_front.sv
`default_nettype none
module b64e_front
  import b64e_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  input  wire logic     q_full,
  output logic          q_push,
  output group_t        q_data
);

  logic [BYTE_W-1:0] pend0_r, pend0_nxt;
  logic [BYTE_W-1:0] pend1_r, pend1_nxt;
  logic [1:0]        held_r, held_nxt;
  logic              accept;
  logic              close;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign close    = (held_r == 2'd2) || in_item.end_of_message;
  assign q_push   = accept && close;

  always_comb begin
    q_data.eom    = in_item.end_of_message;
    q_data.nbytes = held_r + 2'd1;
    unique case (held_r)
      2'd0:    q_data.bits = {in_item.data_byte, 16'h0000};
      2'd1:    q_data.bits = {pend0_r, in_item.data_byte, 8'h00};
      default: q_data.bits = {pend0_r, pend1_r, in_item.data_byte};
    endcase
  end

  always_comb begin
    pend0_nxt = pend0_r;
    pend1_nxt = pend1_r;
    held_nxt  = held_r;
    if (accept) begin
      if (close) begin
        held_nxt = 2'd0;
      end else begin
        held_nxt = held_r + 2'd1;
        if (held_r == 2'd0) begin
          pend0_nxt = in_item.data_byte;
        end else begin
          pend1_nxt = in_item.data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pend0_r <= pend0_nxt;
    pend1_r <= pend1_nxt;
    if (!rst_n) begin
      held_r <= 2'd0;
    end else begin
      held_r <= held_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/b64e_queue.sv
`default_nettype none
module b64e_queue
  import b64e_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire group_t push_data,
  input  wire logic   pop,
  output logic        full,
  output logic        valid,
  output group_t      head
);

  group_t     mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

endmodule
`default_nettype wire

### hw/rtl/b64e_back.sv
`default_nettype none
module b64e_back
  import b64e_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_valid,
  input  wire group_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output out_item_t   out_item
);

  group_t     grp_r, grp_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic       active_r, active_nxt;
  logic       ovalid_r, ovalid_nxt;
  out_item_t  oitem_r, oitem_nxt;
  logic       advance;
  logic       finishing;
  logic [SEXTET_W-1:0] sextet;
  out_item_t  cur;

  assign advance   = active_r && (!ovalid_r || !out_stall);
  assign finishing = advance && (pos_r == POS_FOURTH);
  assign q_pop     = q_valid && (!active_r || finishing);

  always_comb begin
    unique case (pos_r)
      POS_FIRST:  sextet = grp_r.bits[23:18];
      POS_SECOND: sextet = grp_r.bits[17:12];
      POS_THIRD:  sextet = grp_r.bits[11:6];
      POS_FOURTH: sextet = grp_r.bits[5:0];
    endcase
    cur.symbol = b64_char(sextet);
    // pad where the group ran short of bytes
    if ((pos_r == POS_THIRD && grp_r.nbytes < 2'd2) ||
        (pos_r == POS_FOURTH && grp_r.nbytes < 2'd3)) begin
      cur.symbol = PAD_CHAR;
    end
    cur.last_symbol = grp_r.eom && (pos_r == POS_FOURTH);
  end

  always_comb begin
    grp_nxt    = grp_r;
    pos_nxt    = pos_r;
    active_nxt = active_r;
    ovalid_nxt = ovalid_r;
    oitem_nxt  = oitem_r;
    if (advance) begin
      oitem_nxt  = cur;
      ovalid_nxt = 1'b1;
      pos_nxt    = pos_r + 2'd1;
      if (finishing) begin
        active_nxt = 1'b0;
      end
    end else if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
    if (q_pop) begin
      grp_nxt    = q_head;
      pos_nxt    = POS_FIRST;
      active_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    grp_r   <= grp_nxt;
    oitem_r <= oitem_nxt;
    if (!rst_n) begin
      pos_r    <= POS_FIRST;
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;
  assign out_item  = oitem_r;

  a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!active_r || finishing))
    else $error("group loaded over one still in progress");

  a_last_on_fourth: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cur.last_symbol) |-> (pos_r == POS_FOURTH))
    else $error("last mark away from fourth symbol");

  a_continue_group: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && pos_r != POS_FOURTH) |=> (active_r && ovalid_r))
    else $error("group dropped before fourth symbol");

endmodule
`default_nettype wire

### hw/rtl/base64_stream_encoder.sv
`default_nettype none
// Base64 (standard alphabet, '=' padding) stream encoder. One byte is taken per transfer
// on the input side, with end_of_message on the final byte of a message; each group of
// three bytes, or the shorter group closed by end_of_message, yields four symbols, the
// fourth of the closing group carrying last_symbol. Input transfers can follow one per
// cycle while the two-entry group queue has room; the output side sends one symbol per
// cycle unless out_stall holds it, so the sustained rate is set by the symbol sequencer,
// which sends four symbols per group. A closed group passes through the group queue,
// the sequencer's group register and the output register before its first symbol appears.
module base64_stream_encoder
  import b64e_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_valid;
  group_t q_wdata;
  group_t q_head;

  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  b64e_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
